// ----- rtl/ubh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubh_pkg
// Shared types and constants of the uniform-bin histogram.
// ----------------------------------------------------------------------------
package ubh_pkg;

   localparam int BINS_W    = 9;    // bins_in_use register width
   localparam int FIELD_W   = 32;   // sample and limit field width
   localparam int CNT_W     = 32;   // every counter
   localparam int HIT_W     = 8;    // reported bin index
   localparam int OUTC_W    = 3;    // outcome code
   localparam int CSR_IDX_W = 2;
   localparam int RSP_DATA_W = 136; // hit_bin + 4 counters, whole bytes

   typedef enum logic [OUTC_W-1:0] {
      OUT_BINNED  = 3'd0,
      OUT_UNDER   = 3'd1,
      OUT_OVER    = 3'd2,
      OUT_INVALID = 3'd3,
      OUT_BADCFG  = 3'd4
   } outcome_type;

   localparam logic [CSR_IDX_W-1:0] REG_MIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BINS = 2'd2;

   localparam logic [FIELD_W-1:0] RST_MIN  = 32'd0;
   localparam logic [FIELD_W-1:0] RST_MAX  = 32'd65536;
   localparam logic [BINS_W-1:0]  RST_BINS = 9'd256;

   typedef struct packed {
      logic clear;      // write zero at the sweep address
      logic accept;     // capture input beat
      logic classify;   // classify, bump side counters
      logic mul;        // offset * bins
      logic div_load;   // seed remainder
      logic div_step;   // one quotient bit
      logic pick;       // final bin index
      logic read;       // bin read
      logic write;      // bin write-back
      logic load_out;   // fill output register
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic binned;
   } dp_status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 32'd1;
   endfunction

endpackage

// ----- rtl/uniform_bin_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_bin_histogram
// Fixed-width histogram with underflow, overflow and invalid counters.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ beats carry one Q16.16 sample and a not-finite flag; each gives
//    exactly one rsp_ beat with the outcome, the bin hit and all totals.
//  - csr_ writes set minimum (0), maximum (1) and bin count (2); write only
//    while no beat is in flight. Index 3 is ignored.
//  - One beat at a time: a binned sample goes from accept through classify,
//    multiply, restoring divide, bin RAM read and write-back and output
//    load before the next accept; any other outcome goes from classify
//    straight to output load. The divider loop gives one quotient bit per cycle.
//  - rsp_tvalid is registered and rises together with the loaded result.
//    The output register decouples the sides: a new beat is taken while
//    a result waits, and the block only holds in its last step if the
//    previous result is still not taken.
//  - After reset the bin RAM is swept to zero, one bin per cycle, all
//    MAX_BINS bins with req_tready low; config writes are taken meanwhile.
//  - Counters saturate at all ones; bins keep their counts over csr writes.
// ----------------------------------------------------------------------------
module uniform_bin_histogram #(
   parameter int MAX_BINS     = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // config write port
   input  logic                               csr_we,
   input  logic [ubh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ubh_pkg::FIELD_W-1:0]        csr_wdata,
   // sample beats
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ubh_pkg::FIELD_W-1:0]        req_tdata,  // [31:0] sample_value
   input  logic                               req_tuser,  // [0] not_finite
   // result beats
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] hit_bin, [39:8] hit_bin_total, [71:40] below_total,
   // [103:72] above_total, [135:104] rejected_total
   output logic [ubh_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [ubh_pkg::OUTC_W-1:0]         rsp_tuser   // [2:0] outcome
);
   import ubh_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   // sequencer: owns the handshake flags
   ubh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // datapath: config, arithmetic, bin RAM, payload registers
   ubh_dpath #(
      .MAX_BINS     (MAX_BINS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

`ifndef SYNTHESIS
   // one beat in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat accepted while busy");

   // no beat is taken during the clearing sweep
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_tready)
      else $error("beat accepted during bin clear");

   // a result that is not binned reports no bin
   a_unbinned_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != OUT_BINNED |-> rsp_tdata[39:0] == '0)
      else $error("bin fields set on an unbinned result");

   // output load only when the output slot is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_tvalid || rsp_tready)
      else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/ubh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubh_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ubh_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ubh_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubh_dpath
// Histogram datapath: config registers, classifier, multiplier, restoring
// divider, bin RAM read-modify-write, side counters and output register.
// ----------------------------------------------------------------------------
module ubh_dpath #(
   parameter int MAX_BINS     = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ubh_pkg::dp_cmd_type                cmd,
   output ubh_pkg::dp_status_type             st,
   input  logic                               csr_we,
   input  logic [ubh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ubh_pkg::FIELD_W-1:0]        csr_wdata,
   input  logic [ubh_pkg::FIELD_W-1:0]        req_tdata,
   input  logic                               req_tuser,
   output logic [ubh_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [ubh_pkg::OUTC_W-1:0]         rsp_tuser
);
   import ubh_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int PW     = SW + BINS_W;
   localparam int BIDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

   // truncate or zero-extend a 32-bit field to SW bits
   function automatic logic [SW-1:0] ext_field(input logic [FIELD_W-1:0] d);
      logic [SW-1:0] r;
      r = '0;
      for (int i = 0; i < SW; i++) begin
         if (i < FIELD_W) r[i] = d[i[4:0]];
      end
      return r;
   endfunction

   logic [FIELD_W-1:0] min_ff, min_in;
   logic [FIELD_W-1:0] max_ff, max_in;
   logic [BINS_W-1:0]  bins_ff, bins_in;

   logic [SW-1:0]      sample_ff;
   logic               flag_ff;

   outcome_type        outcome_ff;
   logic               eq_hi_ff;
   logic [SW-1:0]      off_ff;
   logic [SW-1:0]      span_ff;
   logic [PW-1:0]      prod_ff;
   logic [SW-1:0]      rem_ff;
   logic [BINS_W-1:0]  low_ff;
   logic [BINS_W-1:0]  quot_ff;
   logic [BIDX_W-1:0]  idx_ff;
   logic [HIT_W-1:0]   hit_ff;
   logic [CNT_W-1:0]   total_ff;
   logic [CNT_W-1:0]   below_ff, above_ff, rejected_ff;
   logic [BIDX_W-1:0]  clr_ff;

   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [OUTC_W-1:0]     rsp_tuser_ff;

   logic signed [SW-1:0] v_s, lo_s, hi_s;
   logic [BINS_W-1:0]    nb;
   outcome_type          cls;
   logic [SW:0]          trial;
   logic [SW:0]          trial_diff;
   logic [BINS_W-1:0]    idx9;
   logic [CNT_W-1:0]     rd_data;
   logic [CNT_W-1:0]     bumped;

   assign v_s  = sample_ff;
   assign lo_s = ext_field(min_ff);
   assign hi_s = ext_field(max_ff);

   // bins_in_use above MAX_BINS is clipped
   assign nb = (13'(bins_ff) > 13'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bins_ff;

   always_comb begin
      if (hi_s <= lo_s || bins_ff == '0) begin
         cls = OUT_BADCFG;
      end else if (flag_ff) begin
         cls = OUT_INVALID;
      end else if (v_s < lo_s) begin
         cls = OUT_UNDER;
      end else if (v_s > hi_s) begin
         cls = OUT_OVER;
      end else begin
         cls = OUT_BINNED;
      end
   end

   // restoring divider step: remainder stays below span
   assign trial      = {rem_ff, low_ff[BINS_W-1]};
   assign trial_diff = trial - {1'b0, span_ff};

   always_comb begin
      if (eq_hi_ff || quot_ff >= nb) begin
         idx9 = nb - 9'd1;
      end else begin
         idx9 = quot_ff;
      end
   end

   assign bumped = sat_inc(rd_data);

   always_comb begin
      min_in  = min_ff;
      max_in  = max_ff;
      bins_in = bins_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MIN:  min_in  = csr_wdata;
            REG_MAX:  max_in  = csr_wdata;
            REG_BINS: bins_in = csr_wdata[BINS_W-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= RST_MIN;
         max_ff      <= RST_MAX;
         bins_ff     <= RST_BINS;
         below_ff    <= '0;
         above_ff    <= '0;
         rejected_ff <= '0;
         clr_ff      <= '0;
      end else begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         bins_ff <= bins_in;
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.classify) begin
            case (cls)
               OUT_UNDER:   below_ff    <= sat_inc(below_ff);
               OUT_OVER:    above_ff    <= sat_inc(above_ff);
               OUT_INVALID: rejected_ff <= sat_inc(rejected_ff);
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= ext_field(req_tdata);
         flag_ff   <= req_tuser;
      end
      if (cmd.classify) begin
         outcome_ff <= cls;
         eq_hi_ff   <= (v_s == hi_s);
         off_ff     <= v_s - lo_s;
         span_ff    <= hi_s - lo_s;
         hit_ff     <= '0;
         total_ff   <= '0;
      end
      if (cmd.mul) begin
         prod_ff <= PW'(off_ff) * PW'(nb);
      end
      if (cmd.div_load) begin
         rem_ff  <= prod_ff[PW-1:BINS_W];
         low_ff  <= prod_ff[BINS_W-1:0];
         quot_ff <= '0;
      end
      if (cmd.div_step) begin
         low_ff <= {low_ff[BINS_W-2:0], 1'b0};
         if (!trial_diff[SW]) begin
            rem_ff  <= trial_diff[SW-1:0];
            quot_ff <= {quot_ff[BINS_W-2:0], 1'b1};
         end else begin
            rem_ff  <= trial[SW-1:0];
            quot_ff <= {quot_ff[BINS_W-2:0], 1'b0};
         end
      end
      if (cmd.pick) begin
         idx_ff <= BIDX_W'(idx9);
         hit_ff <= HIT_W'(idx9);
      end
      if (cmd.write) begin
         total_ff <= bumped;
      end
      if (cmd.load_out) begin
         rsp_tdata_ff <= {rejected_ff, above_ff, below_ff, total_ff, hit_ff};
         rsp_tuser_ff <= outcome_ff;
      end
   end

   ubh_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (cmd.clear | cmd.write),
      .wr_addr (cmd.clear ? clr_ff : idx_ff),
      .wr_data (cmd.clear ? '0 : bumped),
      .rd_en   (cmd.read),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign st.clear_last = (clr_ff == BIDX_W'(MAX_BINS - 1));
   assign st.binned     = (cls == OUT_BINNED);

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule

// ----- rtl/ubh_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubh_ctrl
// Sequencer of the histogram: clearing sweep, per-beat steps, output valid.
// ----------------------------------------------------------------------------
module ubh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   output ubh_pkg::dp_cmd_type    cmd,
   input  ubh_pkg::dp_status_type st,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready
);
   import ubh_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR  = 10'b00_0000_0001,
      S_IDLE   = 10'b00_0000_0010,
      S_CLASS  = 10'b00_0000_0100,
      S_MUL    = 10'b00_0000_1000,
      S_LOAD   = 10'b00_0001_0000,
      S_DIV    = 10'b00_0010_0000,
      S_PICK   = 10'b00_0100_0000,
      S_READ   = 10'b00_1000_0000,
      S_WRITE  = 10'b01_0000_0000,
      S_FINISH = 10'b10_0000_0000
   } state_type;

   localparam logic [3:0] DIV_LAST = 4'(BINS_W - 1);

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_CLASS;
            end
         end
         S_CLASS: begin
            cmd.classify = 1'b1;
            state_in     = st.binned ? S_MUL : S_FINISH;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 4'd1;
            if (step_ff == DIV_LAST) state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule
